>>> src/tet_pkg.sv
// ----------------------------------------------------------------------------
// Timed event table package
// Shared constants, codes and types of the timed event table.
// ----------------------------------------------------------------------------
package tet_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_POS_BITS    = 24;

    localparam int TYPE_BITS     = 6;
    localparam int SLOT_BITS     = 6;
    localparam int RADIUS_BITS   = 23;
    localparam int RSQ_BITS      = 2 * RADIUS_BITS;
    localparam int FIXED_IN_BITS = 109;
    localparam int OUT_DATA_W    = 16;

    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 23'd15360;

    localparam logic [2:0] KIND_REG_ENT = 3'd0;
    localparam logic [2:0] KIND_REG_POS = 3'd1;
    localparam logic [2:0] KIND_TICK    = 3'd2;
    localparam logic [2:0] KIND_FIRST   = 3'd3;
    localparam logic [2:0] KIND_CLEAR   = 3'd4;
    localparam logic [2:0] KIND_NEAR    = 3'd5;

    localparam logic [1:0] MARK_NORMAL    = 2'd0;
    localparam logic [1:0] MARK_DELETABLE = 2'd1;
    localparam logic [1:0] MARK_CLEARED   = 2'd2;

    localparam logic [1:0] OUT_NONE    = 2'd0;
    localparam logic [1:0] OUT_REFRESH = 2'd1;
    localparam logic [1:0] OUT_INSERT  = 2'd2;
    localparam logic [1:0] OUT_FULL    = 2'd3;

    localparam logic [1:0] CFG_AUTO_CLEAR = 2'd0;
    localparam logic [1:0] CFG_RADIUS     = 2'd1;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_REG_ENT,
        OP_REG_POS,
        OP_TICK,
        OP_FIRST,
        OP_CLEAR,
        OP_NEAR
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [TYPE_BITS-1:0] etype;
        logic [1:0]           ekind;
        logic [31:0]          eref;
        logic [31:0]          deadline;
        logic [31:0]          now;
        logic [SLOT_BITS-1:0] sidx;
    } t_cmd;

    typedef struct packed {
        logic [1:0]           outcome;
        logic [SLOT_BITS-1:0] slot;
        logic                 found;
    } t_res;

endpackage

>>> src/tet_front.sv
// ----------------------------------------------------------------------------
// Timed event table front end
// Accepts input words, decodes them into commands and queues them.
// ----------------------------------------------------------------------------
module tet_front #(
    parameter int POS_BITS = tet_pkg::DEF_POS_BITS,
    parameter int IN_W     = 184
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [IN_W-1:0]         i_s_tdata,
    input  logic [2:0]              i_s_tuser,
    input  logic                    i_hold,
    output logic                    o_cmd_valid,
    input  logic                    i_cmd_ready,
    output tet_pkg::t_cmd           o_cmd,
    output logic [3*POS_BITS-1:0]   o_cmd_pos
);
    import tet_pkg::*;

    localparam int OFF_POS  = 40;
    localparam int OFF_LIFE = OFF_POS + 3 * POS_BITS;
    localparam int OFF_NOW  = OFF_LIFE + 31;
    localparam int OFF_SIDX = OFF_NOW + 32;

    t_cmd                  r_q_cmd [2];
    logic [3*POS_BITS-1:0] r_q_pos [2];
    logic                  r_wp;
    logic                  r_rp;
    logic [1:0]            r_cnt;
    t_cmd                  n_cmd;
    logic                  w_push;
    logic                  w_pop;
    logic [5:0]            w_type;
    logic [1:0]            w_ekind;

    assign w_type     = i_s_tdata[5:0];
    assign w_ekind    = i_s_tdata[7:6];
    assign o_s_tready = (r_cnt != 2'd2) && !i_hold;
    assign w_push     = i_s_tvalid && o_s_tready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop      = o_cmd_valid && i_cmd_ready;
    assign o_cmd      = r_q_cmd[r_rp];
    assign o_cmd_pos  = r_q_pos[r_rp];

    always_comb begin
        n_cmd          = '0;
        n_cmd.etype    = w_type;
        n_cmd.ekind    = w_ekind;
        n_cmd.eref     = i_s_tdata[39:8];
        n_cmd.now      = i_s_tdata[OFF_NOW +: 32];
        n_cmd.deadline = i_s_tdata[OFF_NOW +: 32] + {1'b0, i_s_tdata[OFF_LIFE +: 31]};
        n_cmd.sidx     = i_s_tdata[OFF_SIDX +: SLOT_BITS];
        case (i_s_tuser)
            KIND_REG_ENT: begin
                n_cmd.op = (w_type == '0) ? OP_NONE : OP_REG_ENT;
                if (w_ekind == 2'd0) begin
                    n_cmd.eref = '0;
                end
            end
            KIND_REG_POS: begin
                n_cmd.op    = (w_type == '0) ? OP_NONE : OP_REG_POS;
                n_cmd.ekind = '0;
                n_cmd.eref  = '0;
            end
            KIND_TICK:  n_cmd.op = OP_TICK;
            KIND_FIRST: n_cmd.op = OP_FIRST;
            KIND_CLEAR: n_cmd.op = OP_CLEAR;
            KIND_NEAR:  n_cmd.op = OP_NEAR;
            default:    n_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q_cmd[r_wp] <= n_cmd;
                r_q_pos[r_wp] <= i_s_tdata[OFF_POS +: 3*POS_BITS];
                r_wp          <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

>>> src/tet_back.sv
// ----------------------------------------------------------------------------
// Timed event table back end
// Holds the table memory and scans it one entry per cycle for each command other than a no-op.
// ----------------------------------------------------------------------------
module tet_back #(
    parameter int TABLE_DEPTH = tet_pkg::DEF_TABLE_DEPTH,
    parameter int POS_BITS    = tet_pkg::DEF_POS_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  tet_pkg::t_cmd                 i_cmd,
    input  logic [3*POS_BITS-1:0]         i_cmd_pos,
    input  logic                          i_cfg_valid,
    input  logic [1:0]                    i_cfg_index,
    input  logic [tet_pkg::RADIUS_BITS-1:0] i_cfg_data,
    output logic                          o_clr_busy,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output tet_pkg::t_res                 o_res
);
    import tet_pkg::*;

    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int CW   = (IW > SLOT_BITS) ? IW : SLOT_BITS;
    localparam int SQW  = 2 * POS_BITS;
    localparam int SUMW = SQW + 2;
    localparam int CMPW = (SUMW > RSQ_BITS) ? SUMW : RSQ_BITS;
    localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

    typedef struct packed {
        logic [TYPE_BITS-1:0]  etype;
        logic [1:0]            ekind;
        logic [31:0]           eref;
        logic [3*POS_BITS-1:0] pos;
        logic [31:0]           deadline;
        logic [1:0]            mark;
    } t_entry;

    typedef enum logic [1:0] {S_CLR, S_IDLE, S_SCAN, S_FIN} t_state;

    t_entry                  mem [TABLE_DEPTH];
    t_entry                  r_rd;
    t_state                  r_state;
    logic [IW-1:0]           r_cnt;
    logic                    r_issue_done;
    logic                    r_p1_v;
    logic [IW-1:0]           r_p1_idx;
    logic                    r_p2_v;
    logic                    r_p2_m;
    logic [IW-1:0]           r_p2_idx;
    logic [2:0][POS_BITS-1:0] r_p2_d;
    logic                    r_p3_v;
    logic                    r_p3_m;
    logic [IW-1:0]           r_p3_idx;
    logic [2:0][SQW-1:0]     r_p3_sq;
    t_cmd                    r_cmd;
    logic [3*POS_BITS-1:0]   r_pos;
    logic                    r_found;
    logic [IW-1:0]           r_slot;
    logic [RSQ_BITS-1:0]     r_best;
    logic                    r_match;
    logic [IW-1:0]           r_hit_idx;
    t_entry                  r_hit_ent;
    logic                    r_emp;
    logic [IW-1:0]           r_emp_idx;
    logic [IW-1:0]           r_hint;
    logic [TYPE_BITS-1:0]    r_act;
    logic [RADIUS_BITS-1:0]  r_rad;
    logic [RSQ_BITS-1:0]     r_rsq;
    logic                    r_res_v;
    t_res                    r_res;

    t_entry                  w_tick_ent;
    t_entry                  w_new_ent;
    t_entry                  w_data;
    logic                    w_en;
    logic [IW-1:0]           w_addr;
    logic                    w_m;
    logic [2:0][POS_BITS-1:0] w_d;
    logic [SUMW-1:0]         w_sum;
    logic                    w_out_free;
    logic                    w_is_reg;
    logic                    w_scan_end;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_clr_busy  = (r_state == S_CLR);
    assign o_res_valid = r_res_v;
    assign o_res       = r_res;
    assign w_out_free  = !r_res_v || i_res_ready;
    assign w_is_reg    = (r_cmd.op == OP_REG_ENT) || (r_cmd.op == OP_REG_POS);
    assign w_scan_end  = r_issue_done && !r_p1_v && !r_p2_v && !r_p3_v;

    always_comb begin
        logic signed [POS_BITS:0] a;
        logic signed [POS_BITS:0] b;
        logic signed [POS_BITS:0] df;
        w_tick_ent = r_rd;
        if (r_rd.etype != '0) begin
            if ((r_cmd.now > r_rd.deadline) || (r_rd.mark == MARK_DELETABLE)) begin
                w_tick_ent.etype = '0;
                w_tick_ent.mark  = MARK_NORMAL;
            end else if (r_rd.mark == MARK_CLEARED) begin
                w_tick_ent.mark = MARK_DELETABLE;
            end
        end
        if (r_cmd.op == OP_REG_POS) begin
            w_m = (r_rd.etype == r_cmd.etype) && (r_rd.ekind == 2'd0) && (r_rd.pos == r_pos);
        end else begin
            w_m = (r_rd.etype == r_cmd.etype) && (r_rd.ekind == r_cmd.ekind) &&
                  (r_rd.eref == r_cmd.eref);
        end
        for (int k = 0; k < 3; k++) begin
            a  = {r_pos[k*POS_BITS + POS_BITS - 1], r_pos[k*POS_BITS +: POS_BITS]};
            b  = {r_rd.pos[k*POS_BITS + POS_BITS - 1], r_rd.pos[k*POS_BITS +: POS_BITS]};
            df = a - b;
            w_d[k] = df[POS_BITS] ? POS_BITS'(-df) : df[POS_BITS-1:0];
        end
        w_sum = SUMW'(r_p3_sq[0]) + SUMW'(r_p3_sq[1]) + SUMW'(r_p3_sq[2]);
    end

    always_comb begin
        w_new_ent          = '0;
        w_new_ent.etype    = r_cmd.etype;
        w_new_ent.ekind    = r_cmd.ekind;
        w_new_ent.eref     = r_cmd.eref;
        w_new_ent.pos      = r_pos;
        w_new_ent.deadline = r_cmd.deadline;
        w_new_ent.mark     = ((r_act != '0) && (r_cmd.etype == r_act)) ?
                             MARK_CLEARED : MARK_NORMAL;
        w_en   = 1'b0;
        w_addr = r_cnt;
        w_data = '0;
        case (r_state)
            S_CLR: begin
                w_en = 1'b1;
            end
            S_SCAN: begin
                w_addr = r_p1_idx;
                if (r_p1_v && (r_cmd.op == OP_TICK)) begin
                    w_en   = 1'b1;
                    w_data = w_tick_ent;
                end else if (r_p1_v && (r_cmd.op == OP_CLEAR) &&
                             (CW'(r_p1_idx) == CW'(r_cmd.sidx)) &&
                             (r_rd.mark != MARK_DELETABLE)) begin
                    w_en      = 1'b1;
                    w_data    = r_rd;
                    w_data.mark = MARK_CLEARED;
                end
            end
            S_FIN: begin
                if (w_out_free && w_is_reg) begin
                    if (r_match) begin
                        w_en            = 1'b1;
                        w_addr          = r_hit_idx;
                        w_data          = r_hit_ent;
                        w_data.deadline = r_cmd.deadline;
                    end else if (r_emp) begin
                        w_en   = 1'b1;
                        w_addr = r_emp_idx;
                        w_data = w_new_ent;
                    end
                end
            end
            default: begin
                w_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_rd <= mem[r_cnt];
    end

    always_ff @(posedge i_clk) begin
        r_rsq <= RSQ_BITS'(r_rad) * RSQ_BITS'(r_rad);
        r_p2_d <= w_d;
        for (int k = 0; k < 3; k++) begin
            r_p3_sq[k] <= SQW'(r_p2_d[k]) * SQW'(r_p2_d[k]);
        end
        r_p1_idx <= r_cnt;
        r_p2_idx <= r_p1_idx;
        r_p3_idx <= r_p2_idx;
        r_p2_m   <= (r_rd.etype == r_cmd.etype);
        r_p3_m   <= r_p2_m;
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_cnt        <= '0;
            r_issue_done <= 1'b0;
            r_p1_v       <= 1'b0;
            r_p2_v       <= 1'b0;
            r_p3_v       <= 1'b0;
            r_hint       <= '0;
            r_act        <= '0;
            r_rad        <= RADIUS_RESET;
            r_res_v      <= 1'b0;
            r_found      <= 1'b0;
            r_match      <= 1'b0;
            r_emp        <= 1'b0;
        end else begin
            if (i_cfg_valid && (i_cfg_index == CFG_AUTO_CLEAR)) begin
                r_act <= i_cfg_data[TYPE_BITS-1:0];
            end
            if (i_cfg_valid && (i_cfg_index == CFG_RADIUS)) begin
                r_rad <= i_cfg_data;
            end
            if (r_res_v && i_res_ready) begin
                r_res_v <= 1'b0;
            end
            r_p1_v <= (r_state == S_SCAN) && !r_issue_done;
            r_p2_v <= r_p1_v && (r_cmd.op == OP_NEAR);
            r_p3_v <= r_p2_v;
            case (r_state)
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd        <= i_cmd;
                        r_pos        <= i_cmd_pos;
                        r_cnt        <= '0;
                        r_issue_done <= 1'b0;
                        r_found      <= 1'b0;
                        r_slot       <= '0;
                        r_best       <= r_rsq;
                        r_match      <= 1'b0;
                        r_emp        <= 1'b0;
                        r_state      <= (i_cmd.op == OP_NONE) ? S_FIN : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!r_issue_done) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == LAST) begin
                            r_cnt        <= '0;
                            r_issue_done <= 1'b1;
                        end
                    end
                    if (r_p1_v) begin
                        if ((r_cmd.op == OP_FIRST) && !r_found &&
                            (r_rd.etype == r_cmd.etype)) begin
                            r_found <= 1'b1;
                            r_slot  <= r_p1_idx;
                        end
                        if (w_is_reg && !r_match && w_m) begin
                            r_match   <= 1'b1;
                            r_hit_idx <= r_p1_idx;
                            r_hit_ent <= r_rd;
                        end
                        if (w_is_reg && !r_emp && (r_rd.etype == '0) &&
                            (r_p1_idx >= r_hint)) begin
                            r_emp     <= 1'b1;
                            r_emp_idx <= r_p1_idx;
                        end
                    end
                    if (r_p3_v && r_p3_m && (CMPW'(w_sum) < CMPW'(r_best))) begin
                        r_best  <= RSQ_BITS'(w_sum);
                        r_found <= 1'b1;
                        r_slot  <= r_p3_idx;
                    end
                    if (w_scan_end) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_res_v <= 1'b1;
                        r_res   <= '0;
                        r_state <= S_IDLE;
                        case (r_cmd.op)
                            OP_REG_ENT, OP_REG_POS: begin
                                if (r_match) begin
                                    r_res.found   <= 1'b1;
                                    r_res.slot    <= SLOT_BITS'(r_hit_idx);
                                    r_res.outcome <= OUT_REFRESH;
                                end else if (r_emp) begin
                                    r_res.found   <= 1'b1;
                                    r_res.slot    <= SLOT_BITS'(r_emp_idx);
                                    r_res.outcome <= OUT_INSERT;
                                    r_hint        <= r_emp_idx;
                                end else begin
                                    r_res.outcome <= OUT_FULL;
                                end
                            end
                            OP_TICK: begin
                                r_hint <= '0;
                            end
                            OP_FIRST, OP_NEAR: begin
                                r_res.found <= r_found;
                                r_res.slot  <= SLOT_BITS'(r_slot);
                            end
                            default: begin
                                r_res.outcome <= OUT_NONE;
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/timed_event_table.sv
// ----------------------------------------------------------------------------
// Timed event table
// Table of timed events with registration, expiry, clearing and searches.
// ----------------------------------------------------------------------------
// Every word on the input stream returns exactly one result word. The back end
// handles each word by a scan of the table memory, one entry per cycle, plus the
// read and distance pipeline drain; unused kinds and type zero registrations skip
// the scan. A two-word command queue lets new words be taken while a scan runs.
// After reset the table is cleared, during which no input word is accepted;
// configuration writes are taken at any time.
module timed_event_table #(
    parameter int TABLE_DEPTH = tet_pkg::DEF_TABLE_DEPTH,
    parameter int POS_BITS    = tet_pkg::DEF_POS_BITS,
    parameter int IN_W        = ((tet_pkg::FIXED_IN_BITS + 3 * POS_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // event_type, entity_kind, entity_ref, pos_x, pos_y, pos_z, lifetime_ms,
    // now_ms, slot_index
    input  logic [IN_W-1:0]                 i_s_axis_tdata,
    // kind
    input  logic [2:0]                      i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // found, slot, outcome
    output logic [tet_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [tet_pkg::RADIUS_BITS-1:0] i_cfg_data
);
    import tet_pkg::*;

    t_cmd                  w_cmd;
    logic [3*POS_BITS-1:0] w_cmd_pos;
    logic                  w_cmd_valid;
    logic                  w_cmd_ready;
    logic                  w_clr_busy;
    t_res                  w_res;

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = OUT_DATA_W'(w_res);

    tet_front #(
        .POS_BITS (POS_BITS),
        .IN_W     (IN_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_axis_tvalid),
        .o_s_tready  (o_s_axis_tready),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .i_hold      (w_clr_busy),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd),
        .o_cmd_pos   (w_cmd_pos)
    );

    tet_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .POS_BITS    (POS_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .i_cmd_pos   (w_cmd_pos),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_clr_busy  (w_clr_busy),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (w_res)
    );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed event table testbench
// Drives event words into the table with random idling and stalls, tracks the
// table contents in a behavioral copy, and checks every result word in order.
// ----------------------------------------------------------------------------
module tb_top;
    import tet_pkg::*;

    localparam int DEPTH = 64;
    localparam int IN_W  = 184;
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;

    typedef struct {
        logic [2:0]         kind;
        logic [5:0]         etype;
        logic [1:0]         ekind;
        logic [31:0]        eref;
        logic signed [23:0] px, py, pz;
        logic [30:0]        life;
        logic [31:0]        now;
        logic [5:0]         sidx;
    } ev_word_t;

    typedef struct {
        logic       found;
        logic [5:0] slot;
        logic [1:0] outcome;
    } ev_res_t;

    logic            i_clk = 0;
    logic            i_rst_n = 0;
    logic            i_s_axis_tvalid = 0;
    logic            o_s_axis_tready;
    logic [IN_W-1:0] i_s_axis_tdata = '0;
    logic [2:0]      i_s_axis_tuser = '0;
    logic            o_m_axis_tvalid;
    logic            i_m_axis_tready = 0;
    logic [15:0]     o_m_axis_tdata;
    logic            i_cfg_valid = 0;
    logic            o_cfg_ready;
    logic [1:0]      i_cfg_index = '0;
    logic [22:0]     i_cfg_data = '0;

    timed_event_table dut (.*);

    // Behavioral copy of the table.
    logic [5:0]         tbl_type [DEPTH];
    logic [1:0]         tbl_kind [DEPTH];
    logic [31:0]        tbl_ref  [DEPTH];
    logic signed [23:0] tbl_x [DEPTH], tbl_y [DEPTH], tbl_z [DEPTH];
    logic [31:0]        tbl_dl   [DEPTH];
    logic [1:0]         tbl_mark [DEPTH];
    logic [5:0]         free_hint;
    logic [5:0]         auto_clear;
    logic [22:0]        radius;

    ev_word_t pending_words[$];
    ev_res_t  expected_results[$];
    ev_word_t cur_word;
    int send_idle, recv_idle, rx_hold_cycles, errors, n_words, n_results;
    int n_full, n_insert, n_refresh, n_found;
    bit tx_hold;
    logic [31:0] clock_ms;

    initial forever #2 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("FAIL timed_event_table");
        $finish;
    end

    function automatic ev_res_t table_step(ev_word_t w);
        ev_res_t r;
        logic [1:0] ek;
        logic [31:0] rf, dl;
        longint unsigned best, d, a;
        int i, hit;
        r = '{0, 0, OUT_NONE};
        case (w.kind)
            KIND_REG_ENT, KIND_REG_POS: begin
                if (w.etype == 0) return r;
                ek = (w.kind == KIND_REG_POS) ? 2'd0 : w.ekind;
                rf = (ek == 0) ? 32'd0 : w.eref;
                dl = w.now + {1'b0, w.life};
                hit = -1;
                for (i = 0; i < DEPTH && hit < 0; i++) begin
                    if (w.kind == KIND_REG_POS) begin
                        if (tbl_type[i] == w.etype && tbl_kind[i] == 0 && tbl_x[i] == w.px
                            && tbl_y[i] == w.py && tbl_z[i] == w.pz) hit = i;
                    end else if (tbl_type[i] == w.etype && tbl_kind[i] == ek
                                 && tbl_ref[i] == rf) begin
                        hit = i;
                    end
                end
                if (hit >= 0) begin
                    tbl_dl[hit] = dl;
                    r = '{1, hit[5:0], OUT_REFRESH};
                    return r;
                end
                for (i = free_hint; i < DEPTH && hit < 0; i++)
                    if (tbl_type[i] == 0) hit = i;
                if (hit < 0) begin
                    r.outcome = OUT_FULL;
                    return r;
                end
                free_hint = hit[5:0];
                tbl_type[hit] = w.etype;
                tbl_kind[hit] = ek;
                tbl_ref[hit] = rf;
                tbl_x[hit] = w.px;
                tbl_y[hit] = w.py;
                tbl_z[hit] = w.pz;
                tbl_dl[hit] = dl;
                tbl_mark[hit] = (auto_clear != 0 && w.etype == auto_clear) ?
                                MARK_CLEARED : MARK_NORMAL;
                r = '{1, hit[5:0], OUT_INSERT};
            end
            KIND_TICK: begin
                free_hint = 0;
                for (i = 0; i < DEPTH; i++) begin
                    if (tbl_type[i] != 0) begin
                        if (w.now > tbl_dl[i] || tbl_mark[i] == MARK_DELETABLE) begin
                            tbl_type[i] = 0;
                            tbl_mark[i] = MARK_NORMAL;
                        end
                        if (tbl_mark[i] == MARK_CLEARED) tbl_mark[i] = MARK_DELETABLE;
                    end
                end
            end
            KIND_FIRST: begin
                for (i = DEPTH - 1; i >= 0; i--)
                    if (tbl_type[i] == w.etype) r = '{1, i[5:0], OUT_NONE};
            end
            KIND_CLEAR: begin
                if (tbl_mark[w.sidx] != MARK_DELETABLE) tbl_mark[w.sidx] = MARK_CLEARED;
            end
            KIND_NEAR: begin
                best = longint'(radius) * longint'(radius);
                for (i = 0; i < DEPTH; i++) begin
                    if (tbl_type[i] == w.etype) begin
                        a = longint'(w.px) - longint'(tbl_x[i]);
                        a = a[63] ? -a : a;
                        d = a * a;
                        a = longint'(w.py) - longint'(tbl_y[i]);
                        a = a[63] ? -a : a;
                        d += a * a;
                        a = longint'(w.pz) - longint'(tbl_z[i]);
                        a = a[63] ? -a : a;
                        d += a * a;
                        if (d < best) begin
                            best = d;
                            r = '{1, i[5:0], OUT_NONE};
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Driver: offers pending words, records each accepted one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_results.push_back(table_step(cur_word));
                n_words++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_words.size() > 0 && !tx_hold &&
                    $urandom_range(99) >= send_idle) begin
                    cur_word = pending_words.pop_front();
                    i_s_axis_tvalid <= 1;
                    i_s_axis_tuser <= cur_word.kind;
                    i_s_axis_tdata <= {3'b0, cur_word.sidx, cur_word.now, cur_word.life,
                                       cur_word.pz, cur_word.py, cur_word.px,
                                       cur_word.eref, cur_word.ekind, cur_word.etype};
                end else begin
                    i_s_axis_tvalid <= 0;
                end
            end
        end
    end

    // Receiver: random back pressure plus a long hold-off in the first phase.
    always @(posedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles <= rx_hold_cycles - 1;
            i_m_axis_tready <= 0;
        end else begin
            i_m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_idle);
        end
    end

    // Monitor: compares each result word with the oldest expectation.
    always @(posedge i_clk) begin
        ev_res_t e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_results++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word %h", $time, o_m_axis_tdata);
            end else begin
                e = expected_results.pop_front();
                if (o_m_axis_tdata[0] != e.found || o_m_axis_tdata[6:1] != e.slot ||
                    o_m_axis_tdata[8:7] != e.outcome || o_m_axis_tdata[15:9] != 0) begin
                    errors++;
                    $display("%0t: expected found %0d slot %0d outcome %0d, got %0d %0d %0d",
                             $time, e.found, e.slot, e.outcome, o_m_axis_tdata[0],
                             o_m_axis_tdata[6:1], o_m_axis_tdata[8:7]);
                end
                if (e.outcome == OUT_FULL) n_full++;
                if (e.outcome == OUT_INSERT) n_insert++;
                if (e.outcome == OUT_REFRESH) n_refresh++;
                if (e.found && e.outcome == OUT_NONE) n_found++;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [22:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        if (idx == CFG_AUTO_CLEAR) auto_clear = val[5:0];
        else radius = val;
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (pending_words.size() > 0 || i_s_axis_tvalid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic queue_word(logic [2:0] k, logic [5:0] t, logic [1:0] ek, logic [31:0] rf,
                              logic [23:0] x, logic [23:0] y, logic [23:0] z,
                              logic [30:0] lf, logic [31:0] nw, logic [5:0] si);
        ev_word_t w;
        w = '{k, t, ek, rf, x, y, z, lf, nw, si};
        pending_words.push_back(w);
    endtask

    function automatic logic [23:0] pick_coord(int base);
        case ($urandom_range(9))
            0: return 24'($urandom);
            1: return 24'(base);
            default: return 24'(base + int'($urandom_range(40)) - 20);
        endcase
    endfunction

    task automatic queue_random(int count, bit bulk);
        logic [2:0] k;
        logic [5:0] t;
        logic [31:0] rf;
        logic [30:0] lf;
        int p, sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (bulk) k = KIND_REG_ENT;
            else if (sel < 30) k = KIND_REG_ENT;
            else if (sel < 50) k = KIND_REG_POS;
            else if (sel < 60) k = KIND_TICK;
            else if (sel < 70) k = KIND_FIRST;
            else if (sel < 78) k = KIND_CLEAR;
            else if (sel < 95) k = KIND_NEAR;
            else k = $urandom_range(1) ? KIND_SPARE_A : KIND_SPARE_B;
            t = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(4));
            if ($urandom_range(7) == 0) t = auto_clear;
            rf = bulk ? 32'(1000 + n) :
                 ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(3));
            lf = ($urandom_range(15) == 0) ? 31'($urandom) : 31'($urandom_range(400));
            p = $urandom_range(3) * 3000 - 4500;
            clock_ms += ($urandom_range(40) == 0) ? $urandom : $urandom_range(30);
            queue_word(k, t, 2'($urandom), rf, pick_coord(p), pick_coord(-p),
                       pick_coord(p / 2), lf, clock_ms, 6'($urandom));
        end
    endtask

    initial begin
        int hold_mode [4][2] = '{'{31, 67}, '{67, 31}, '{0, 0}, '{31, 67}};
        logic [5:0]  ac_set  [4] = '{0, 5, 63, 3};
        logic [22:0] rad_set [4] = '{23'd15360, 23'd0, 23'h7FFFFF, 23'd2000};
        errors = 0;
        n_words = 0;
        n_results = 0;
        n_full = 0;
        n_insert = 0;
        n_refresh = 0;
        n_found = 0;
        tx_hold = 0;
        rx_hold_cycles = 0;
        clock_ms = 1000;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_type[i] = 0; tbl_kind[i] = 0; tbl_ref[i] = 0; tbl_x[i] = 0;
            tbl_y[i] = 0; tbl_z[i] = 0; tbl_dl[i] = 0; tbl_mark[i] = MARK_NORMAL;
        end
        free_hint = 0;
        auto_clear = 0;
        radius = RADIUS_RESET;
        send_idle = 0;
        recv_idle = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_AUTO_CLEAR, 23'(ac_set[ph]));
            write_reg(CFG_RADIUS, rad_set[ph]);
            @(negedge i_clk);
            send_idle = hold_mode[ph][0];
            recv_idle = hold_mode[ph][1];
            if (ph == 0) begin
                queue_word(KIND_REG_ENT, 63, 3, 32'hFFFF_FFFF, 24'h7FFFFF, 24'h7FFFFF,
                           24'h7FFFFF, 31'h7FFF_FFFF, 32'd10, 6'd0);
                queue_word(KIND_REG_ENT, 2, 0, 32'h1234_5678, 0, 0, 0, 100, 20, 0);
                queue_word(KIND_REG_ENT, 2, 0, 32'h9, 0, 0, 0, 200, 30, 0);
                queue_word(KIND_REG_POS, 1, 2, 32'h55, 24'h800000, 24'h800000,
                           24'h800000, 50, 40, 0);
                queue_word(KIND_REG_POS, 1, 1, 32'h66, 24'h800000, 24'h800000,
                           24'h800000, 500, 45, 0);
                queue_word(KIND_REG_ENT, 0, 1, 32'h1, 0, 0, 0, 10, 50, 0);
                queue_word(KIND_REG_ENT, 4, 1, 32'h77, 0, 0, 0, 32'h200, 32'hFFFF_FF00, 0);
                queue_word(KIND_FIRST, 0, 0, 0, 0, 0, 0, 0, 60, 0);
                queue_word(KIND_FIRST, 63, 0, 0, 0, 0, 0, 0, 60, 0);
                queue_word(KIND_FIRST, 7, 0, 0, 0, 0, 0, 0, 60, 0);
                queue_word(KIND_NEAR, 1, 0, 0, 24'h800100, 24'h800000, 24'h800000, 0, 70, 0);
                queue_word(KIND_NEAR, 2, 0, 0, 24'd15360, 0, 0, 0, 70, 0);
                queue_word(KIND_NEAR, 2, 0, 0, 24'd15359, 0, 0, 0, 70, 0);
                queue_word(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 80, 6'd0);
                queue_word(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 80, 6'd63);
                queue_word(KIND_SPARE_A, 6'h3F, 3, 32'hFFFF_FFFF, 24'hFFFFFF, 24'hFFFFFF,
                           24'hFFFFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
                queue_word(KIND_SPARE_B, 1, 1, 1, 1, 1, 1, 1, 1, 1);
                queue_word(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 32'd100, 0);
                queue_word(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 110, 6'd0);
                queue_word(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FF10, 0);
                queue_word(KIND_FIRST, 4, 0, 0, 0, 0, 0, 0, 120, 0);
                queue_word(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 32'd130, 0);
                queue_word(KIND_FIRST, 63, 0, 0, 0, 0, 0, 0, 140, 0);
                rx_hold_cycles = 600;
            end
            if (ph == 2) queue_random(72, 1);
            queue_random(90, 0);
            drain();
            tx_hold = 1;
            queue_random(90, 0);
            repeat (20) @(negedge i_clk);
            tx_hold = 0;
            drain();
        end

        $display("Covered %0d words and %0d results across four settings of both registers:",
                 n_words, n_results);
        $display("%0d inserts, %0d refreshes, %0d table-full, %0d query hits.",
                 n_insert, n_refresh, n_full, n_found);
        if (errors == 0) begin
            $display("PASS timed_event_table");
        end else begin
            $display("FAIL timed_event_table");
        end
        $finish;
    end

endmodule
